FILE: rtl/box_mean_filter_adaptive_threshold_core_macros.svh
// Assertion macros used by the top level of the box-mean filter.
`ifndef BOX_MEAN_FILTER_ADAPTIVE_THRESHOLD_CORE_MACROS_SVH
`define BOX_MEAN_FILTER_ADAPTIVE_THRESHOLD_CORE_MACROS_SVH
// Same-cycle implication, checked on clk, off while rst_n is low.
`define BMFAT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmfat assertion failed");
// Next-cycle implication, checked on clk, off while rst_n is low.
`define BMFAT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmfat assertion failed");
`endif

FILE: rtl/bmfat_pkg.sv
// Package: shared types and constants of the box-mean filter.
`timescale 1ns / 1ps
package bmfat_pkg;
  localparam int MAX_WIDTH_DEF  = 640;
  localparam int MAX_HEIGHT_DEF = 480;
  localparam int MAX_RADIUS_DEF = 7;
  localparam int QUEUE_DEPTH    = 4;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THR_EN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THR_OFS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 3'd6;

  localparam logic [2:0] RADIUS_RST = 3'd1;
  localparam logic [9:0] WIDTH_RST  = 10'd640;
  localparam logic [8:0] HEIGHT_RST = 9'd480;

  typedef struct packed {
    logic [2:0]        radius;
    logic [9:0]        image_width;
    logic [8:0]        image_height;
    logic              color_mode;
    logic              threshold_enable;
    logic signed [8:0] threshold_offset;
    logic              invert_result;
  } cfg_t;
endpackage

FILE: rtl/box_mean_filter_adaptive_threshold_core.sv
// Top level: configuration registers, front/back parts, command queue and line store.
`timescale 1ns / 1ps
`include "box_mean_filter_adaptive_threshold_core_macros.svh"
// Path: an item waits in the input stage and passes the command queue; in the back part a
//   window result takes a window scan (one line-store read per cycle), a flush, a
//   bit-per-cycle divide, widen, luma and emit; store-only items just write the store.
// Flow: each result is emitted before the next pop; input stalls only on a full queue.
// Reset: synchronous active low; registers return to defaults, positions to frame start.
module box_mean_filter_adaptive_threshold_core #(
  parameter int MAX_WIDTH  = bmfat_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmfat_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_RADIUS = bmfat_pkg::MAX_RADIUS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_opcode,
  input  logic [15:0]                      in_pixel_in,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [15:0]                      out_pixel_out,
  output logic                             out_frame_last,
  input  logic                             cfg_we,
  input  logic [bmfat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmfat_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bmfat_pkg::*;

  localparam int DEPTH    = (2*MAX_RADIUS+1)*MAX_WIDTH + 2*MAX_RADIUS + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int PW       = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int WW       = $clog2(MAX_WIDTH+1);
  localparam int HW       = $clog2(MAX_HEIGHT+1);
  localparam int RW       = $clog2(MAX_RADIUS+1);
  localparam int ARW      = $clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1);
  localparam int CMD_W    = 2*AW + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 19;

  cfg_t           cfg_r;
  logic [WW-1:0]  w_r, w_c;
  logic [HW-1:0]  h_r, h_c;
  logic [RW-1:0]  r_r, r_c;
  logic [PW-1:0]  total_r, lag_r;
  logic [ARW-1:0] area_r;

  logic             q_push, q_pop, q_full, q_empty;
  logic [CMD_W-1:0] cmd_in, cmd_out;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [15:0]      ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius           <= RADIUS_RST;
      cfg_r.image_width      <= WIDTH_RST;
      cfg_r.image_height     <= HEIGHT_RST;
      cfg_r.color_mode       <= 1'b0;
      cfg_r.threshold_enable <= 1'b0;
      cfg_r.threshold_offset <= '0;
      cfg_r.invert_result    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIUS:  cfg_r.radius           <= cfg_wdata[2:0];
        REG_WIDTH:   cfg_r.image_width      <= cfg_wdata[9:0];
        REG_HEIGHT:  cfg_r.image_height     <= cfg_wdata[8:0];
        REG_COLOR:   cfg_r.color_mode       <= cfg_wdata[0];
        REG_THR_EN:  cfg_r.threshold_enable <= cfg_wdata[0];
        REG_THR_OFS: cfg_r.threshold_offset <= $signed(cfg_wdata[8:0]);
        REG_INVERT:  cfg_r.invert_result    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (cfg_r.image_width == '0) begin
      w_c = WW'(1);
    end else if (32'(cfg_r.image_width) > MAX_WIDTH) begin
      w_c = WW'(MAX_WIDTH);
    end else begin
      w_c = WW'(cfg_r.image_width);
    end
    if (cfg_r.image_height == '0) begin
      h_c = HW'(1);
    end else if (32'(cfg_r.image_height) > MAX_HEIGHT) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(cfg_r.image_height);
    end
    r_c = (32'(cfg_r.radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(cfg_r.radius);
  end

  always_ff @(posedge clk) begin
    w_r     <= w_c;
    h_r     <= h_c;
    r_r     <= r_c;
    total_r <= PW'(PW'(w_c) * PW'(h_c));
    lag_r   <= PW'(PW'(r_c) * PW'(w_c) + PW'(r_c));
    area_r  <= ARW'(ARW'({r_c, 1'b1}) * ARW'({r_c, 1'b1}));
  end

  bmfat_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_pixel_in (in_pixel_in),
    .w           (w_r),
    .total       (total_r),
    .lag         (lag_r),
    .q_push      (q_push),
    .q_full      (q_full),
    .cmd         (cmd_in)
  );

  bmfat_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (cmd_out),
    .empty (q_empty)
  );

  bmfat_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  bmfat_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .w              (w_r),
    .h              (h_r),
    .r              (r_r),
    .lag            (lag_r),
    .area           (area_r),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .cmd            (cmd_out),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_pixel_out  (out_pixel_out),
    .out_frame_last (out_frame_last)
  );

  `BMFAT_ASSERT_IMP(a_no_push_full, q_push, !q_full || q_pop)
  `BMFAT_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty)
  `BMFAT_ASSERT_NXT(a_push_fills, q_push && !q_pop, !q_empty)
endmodule

FILE: rtl/bmfat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bmfat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule

FILE: rtl/bmfat_queue.sv
// Small register FIFO between the front and back parts.
`timescale 1ns / 1ps
module bmfat_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wp_r, rp_r;
  logic [CNTW-1:0]  cnt_r;

  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTRW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PTRW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end
endmodule

FILE: rtl/bmfat_front.sv
// Front part: takes input beats, tracks frame positions, issues store and window commands.
`timescale 1ns / 1ps
module bmfat_front #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int MAX_RADIUS = 7
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic                                      in_opcode,
  input  logic [15:0]                               in_pixel_in,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]            w,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] total,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] lag,
  output logic                                      q_push,
  input  logic                                      q_full,
  output logic [2*$clog2((2*MAX_RADIUS+1)*MAX_WIDTH+2*MAX_RADIUS+1)
                + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 18:0] cmd
);
  import bmfat_pkg::*;

  localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH + 2*MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(MAX_WIDTH*MAX_HEIGHT+1);
  localparam int WW    = $clog2(MAX_WIDTH+1);
  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int YB    = $clog2(MAX_HEIGHT);

  logic          hold_valid_r;
  logic          hold_op_r;
  logic [15:0]   hold_pix_r;
  logic [PW-1:0] q_r, p_r;
  logic [AW-1:0] qa_r, pa_r;
  logic [XB-1:0] px_r;
  logic [YB-1:0] py_r;

  logic q_in_frame, skip, do_wr, p_out, wait_lag, do_out, need_push, proceed, last;

  assign q_in_frame = (q_r < total);
  assign skip       = hold_op_r && q_in_frame;
  assign do_wr      = !hold_op_r && q_in_frame;
  assign p_out      = (p_r >= total);
  assign wait_lag   = ((PW+1)'(q_r) < ((PW+1)'(p_r) + (PW+1)'(lag)));
  assign do_out     = !skip && !p_out && !wait_lag;
  assign need_push  = !skip && (do_wr || do_out);
  assign proceed    = hold_valid_r && (!need_push || !q_full);
  assign q_push     = proceed && need_push;
  assign in_ready   = !hold_valid_r || proceed;
  assign last       = (p_r == total - 1'b1);

  assign cmd = {do_wr, qa_r, hold_pix_r, do_out, pa_r, px_r, py_r, last};

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_op_r  <= in_opcode;
      hold_pix_r <= in_pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      q_r  <= '0;
      p_r  <= '0;
      qa_r <= '0;
      pa_r <= '0;
      px_r <= '0;
      py_r <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid_r <= 1'b1;
      end else if (proceed) begin
        hold_valid_r <= 1'b0;
      end
      if (proceed && !skip) begin
        if (p_out || (do_out && last)) begin
          q_r  <= '0;
          p_r  <= '0;
          qa_r <= '0;
          pa_r <= '0;
          px_r <= '0;
          py_r <= '0;
        end else begin
          q_r  <= q_r + 1'b1;
          qa_r <= (qa_r == AW'(DEPTH - 1)) ? '0 : qa_r + 1'b1;
          if (do_out) begin
            p_r  <= p_r + 1'b1;
            pa_r <= (pa_r == AW'(DEPTH - 1)) ? '0 : pa_r + 1'b1;
            if (WW'(px_r) + 1'b1 == w) begin
              px_r <= '0;
              py_r <= py_r + 1'b1;
            end else begin
              px_r <= px_r + 1'b1;
            end
          end
        end
      end
    end
  end
endmodule

FILE: rtl/bmfat_back.sv
// Back part: writes the line store, scans the window, divides, thresholds when enabled and emits results.
`timescale 1ns / 1ps
module bmfat_back #(
  parameter int MAX_WIDTH  = 640,
  parameter int MAX_HEIGHT = 480,
  parameter int MAX_RADIUS = 7
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  bmfat_pkg::cfg_t                           cfg,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]            w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]           h,
  input  logic [$clog2(MAX_RADIUS+1)-1:0]           r,
  input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT+1)-1:0] lag,
  input  logic [$clog2((2*MAX_RADIUS+1)*(2*MAX_RADIUS+1)+1)-1:0] area,
  input  logic                                      q_empty,
  output logic                                      q_pop,
  input  logic [2*$clog2((2*MAX_RADIUS+1)*MAX_WIDTH+2*MAX_RADIUS+1)
                + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 18:0] cmd,
  output logic                                      ram_we,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH+2*MAX_RADIUS+1)-1:0] ram_waddr,
  output logic [15:0]                               ram_wdata,
  output logic                                      ram_re,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH+2*MAX_RADIUS+1)-1:0] ram_raddr,
  input  logic [15:0]                               ram_rdata,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [15:0]                               out_pixel_out,
  output logic                                      out_frame_last
);
  import bmfat_pkg::*;

  localparam int DEPTH    = (2*MAX_RADIUS+1)*MAX_WIDTH + 2*MAX_RADIUS + 1;
  localparam int AW       = $clog2(DEPTH);
  localparam int XB       = $clog2(MAX_WIDTH);
  localparam int YB       = $clog2(MAX_HEIGHT);
  localparam int XS       = XB + 2;
  localparam int YS       = YB + 2;
  localparam int RW       = $clog2(MAX_RADIUS+1);
  localparam int KW       = RW + 1;
  localparam int MAX_AREA = (2*MAX_RADIUS+1)*(2*MAX_RADIUS+1);
  localparam int ARW      = $clog2(MAX_AREA+1);
  localparam int SSUM     = 8 + ARW;
  localparam int CW       = $clog2(SSUM);
  localparam int LANES    = 4;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_FLUSH = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_WIDEN = 7'b0010000,
    S_LUMA  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } st_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [12:0] x;
    logic [26:0] m;
    x = {v, 8'b0} - 13'(v) + 13'd15;
    m = 27'(x) * 27'd8457;
    return m[25:18];
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [13:0] x;
    logic [28:0] m;
    x = {v, 8'b0} - 14'(v) + 14'd31;
    m = 29'(x) * 29'd16645;
    return m[27:20];
  endfunction

  function automatic logic [7:0] luma(input logic [7:0] rv, input logic [7:0] gv,
                                      input logic [7:0] bv);
    logic [14:0] s;
    s = 15'(rv) * 15'd38 + 15'(gv) * 15'd75 + 15'(bv) * 15'd15;
    return s[14:7];
  endfunction

  logic          c_wr_en, c_out_en, c_last;
  logic [AW-1:0] c_wr_addr, c_pa;
  logic [15:0]   c_wr_data;
  logic [XB-1:0] c_px;
  logic [YB-1:0] c_py;

  assign {c_wr_en, c_wr_addr, c_wr_data, c_out_en, c_pa, c_px, c_py, c_last} = cmd;

  st_t                 st_r, st_nxt;
  logic [KW-1:0]       j_r, k_r;
  logic signed [YS-1:0] yy_r;
  logic signed [XS-1:0] xx_r, xx0_r;
  logic [AW-1:0]       row_r;
  logic                last_r;
  logic                tag_v_r, tag_c_r;
  logic [15:0]         centre_r;
  logic [SSUM-1:0]     sum_r [LANES];
  logic [SSUM-1:0]     sum_nxt [LANES];
  logic [SSUM-1:0]     lane_val [LANES];
  logic [SSUM-1:0]     num_r [LANES];
  logic [SSUM-1:0]     num_nxt [LANES];
  logic [ARW-1:0]      rem_r [LANES];
  logic [ARW-1:0]      rem_nxt [LANES];
  logic [CW-1:0]       cnt_r;
  logic [7:0]          mr8_r, mg8_r, mb8_r, cr8_r, cg8_r, cb8_r;
  logic [7:0]          ym_r, yc_r;
  logic                out_valid_r, out_last_r;
  logic [15:0]         out_pixel_r;

  logic                pop, emit_go, k_end, j_end, in_img, is_ctr;
  logic [AW:0]         start_sum, start_addr, addr_sum, row_sum;
  logic [KW-1:0]       two_r;
  logic [7:0]          mean8, cen8;
  logic [15:0]         mean565, result;
  logic signed [10:0]  lhs, rhs;
  logic                hit;

  assign pop   = (st_r == S_IDLE) && !q_empty;
  assign q_pop = pop;

  assign ram_we    = pop && c_wr_en;
  assign ram_waddr = c_wr_addr;
  assign ram_wdata = c_wr_data;

  assign start_sum  = (AW+1)'(c_pa) + (AW+1)'(DEPTH) - (AW+1)'(lag);
  assign start_addr = (start_sum >= (AW+1)'(DEPTH)) ? start_sum - (AW+1)'(DEPTH) : start_sum;

  assign addr_sum  = (AW+1)'(row_r) + (AW+1)'(k_r);
  assign ram_raddr = (addr_sum >= (AW+1)'(DEPTH)) ? AW'(addr_sum - (AW+1)'(DEPTH))
                                                   : AW'(addr_sum);
  assign ram_re    = (st_r == S_SCAN);
  assign row_sum   = (AW+1)'(row_r) + (AW+1)'(w);

  assign two_r  = {r, 1'b0};
  assign k_end  = (k_r == two_r);
  assign j_end  = (j_r == two_r);
  assign in_img = !yy_r[YS-1] && ($unsigned(yy_r) < YS'(h)) &&
                  !xx_r[XS-1] && ($unsigned(xx_r) < XS'(w));
  assign is_ctr = (j_r == KW'(r)) && (k_r == KW'(r));

  always_comb begin
    lane_val[0] = SSUM'(ram_rdata[7:0]);
    lane_val[1] = SSUM'(ram_rdata[15:11]);
    lane_val[2] = SSUM'(ram_rdata[10:5]);
    lane_val[3] = SSUM'(ram_rdata[4:0]);
    for (int i = 0; i < LANES; i++) begin
      sum_nxt[i] = sum_r[i] + (tag_v_r ? lane_val[i] : '0);
    end
  end

  always_comb begin
    logic [ARW:0] t;
    logic         ge;
    for (int i = 0; i < LANES; i++) begin
      t  = {rem_r[i], num_r[i][SSUM-1]};
      ge = (t >= (ARW+1)'(area));
      rem_nxt[i] = ge ? ARW'(t - (ARW+1)'(area)) : ARW'(t);
      num_nxt[i] = {num_r[i][SSUM-2:0], ge};
    end
  end

  assign mean8   = num_r[0][7:0];
  assign mean565 = {num_r[1][4:0], num_r[2][5:0], num_r[3][4:0]};
  assign cen8    = cfg.color_mode ? yc_r : centre_r[7:0];
  assign lhs     = $signed({3'b0, (cfg.color_mode ? ym_r : mean8)})
                   - $signed({{2{cfg.threshold_offset[8]}}, cfg.threshold_offset});
  assign rhs     = $signed({3'b0, cen8});
  assign hit     = (lhs < rhs) ^ cfg.invert_result;

  always_comb begin
    if (cfg.threshold_enable) begin
      if (cfg.color_mode) begin
        result = hit ? 16'hFFFF : 16'h0000;
      end else begin
        result = hit ? 16'h00FF : 16'h0000;
      end
    end else begin
      result = cfg.color_mode ? mean565 : {8'b0, mean8};
    end
  end

  assign emit_go = (st_r == S_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (pop && c_out_en) begin
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_end && j_end) begin
          st_nxt = S_FLUSH;
        end
      end
      S_FLUSH: st_nxt = S_DIV;
      S_DIV: begin
        if (cnt_r == CW'(SSUM - 1)) begin
          st_nxt = S_WIDEN;
        end
      end
      S_WIDEN: st_nxt = S_LUMA;
      S_LUMA:  st_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_go) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      tag_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      tag_v_r <= (st_r == S_SCAN) && in_img;
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_c_r <= (st_r == S_SCAN) && is_ctr;
    if (tag_c_r) begin
      centre_r <= ram_rdata;
    end
    if (emit_go) begin
      out_pixel_r <= result;
      out_last_r  <= last_r;
    end
    case (st_r)
      S_IDLE: begin
        if (pop && c_out_en) begin
          j_r    <= '0;
          k_r    <= '0;
          yy_r   <= $signed(YS'(c_py)) - $signed(YS'(r));
          xx_r   <= $signed(XS'(c_px)) - $signed(XS'(r));
          xx0_r  <= $signed(XS'(c_px)) - $signed(XS'(r));
          row_r  <= AW'(start_addr);
          last_r <= c_last;
          for (int i = 0; i < LANES; i++) begin
            sum_r[i] <= '0;
          end
        end
      end
      S_SCAN: begin
        for (int i = 0; i < LANES; i++) begin
          sum_r[i] <= sum_nxt[i];
        end
        if (k_end) begin
          k_r   <= '0;
          xx_r  <= xx0_r;
          j_r   <= j_r + 1'b1;
          yy_r  <= yy_r + 1'b1;
          row_r <= (row_sum >= (AW+1)'(DEPTH)) ? AW'(row_sum - (AW+1)'(DEPTH))
                                                : AW'(row_sum);
        end else begin
          k_r  <= k_r + 1'b1;
          xx_r <= xx_r + 1'b1;
        end
      end
      S_FLUSH: begin
        cnt_r <= '0;
        for (int i = 0; i < LANES; i++) begin
          num_r[i] <= sum_nxt[i];
          rem_r[i] <= '0;
        end
      end
      S_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        for (int i = 0; i < LANES; i++) begin
          num_r[i] <= num_nxt[i];
          rem_r[i] <= rem_nxt[i];
        end
      end
      S_WIDEN: begin
        mr8_r <= widen5(mean565[15:11]);
        mg8_r <= widen6(mean565[10:5]);
        mb8_r <= widen5(mean565[4:0]);
        cr8_r <= widen5(centre_r[15:11]);
        cg8_r <= widen6(centre_r[10:5]);
        cb8_r <= widen5(centre_r[4:0]);
      end
      S_LUMA: begin
        ym_r <= luma(mr8_r, mg8_r, mb8_r);
        yc_r <= luma(cr8_r, cg8_r, cb8_r);
      end
      S_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_pixel_out  = out_pixel_r;
  assign out_frame_last = out_last_r;
endmodule

FILE: test/box_mean_filter_adaptive_threshold_core_test.sv
// Testbench of the box-mean filter core: predicted frames compared beat by beat.
`timescale 1ns / 1ps
module box_mean_filter_adaptive_threshold_core_test;
  import bmfat_pkg::*;

  localparam int STORE_DEPTH = (2 * MAX_RADIUS_DEF + 1) * MAX_WIDTH_DEF + 2 * MAX_RADIUS_DEF + 1;
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct {
    logic [15:0] pixel;
    logic        last;
  } mean_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = 1'b0;
  logic [15:0] in_pixel_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_pixel_out;
  logic out_frame_last;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  mean_beat_t expected_means[$];
  int errors = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  // shadow of the block's state
  logic [15:0] pixel_mem [STORE_DEPTH];
  int unsigned in_pos = 0;
  int unsigned out_pos = 0;
  logic [2:0] sh_radius = RADIUS_RST;
  logic [9:0] sh_width = WIDTH_RST;
  logic [8:0] sh_height = HEIGHT_RST;
  logic sh_color = 1'b0;
  logic sh_thr_en = 1'b0;
  logic signed [8:0] sh_offset = '0;
  logic sh_invert = 1'b0;

  box_mean_filter_adaptive_threshold_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_pixel_out(out_pixel_out),
    .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic int luma565(input logic [15:0] px);
    int unsigned r8, g8, b8;
    r8 = (int'(px[15:11]) * 255 + 15) / 31;
    g8 = (int'(px[10:5]) * 255 + 31) / 63;
    b8 = (int'(px[4:0]) * 255 + 15) / 31;
    return int'((38 * r8 + 75 * g8 + 15 * b8) >> 7);
  endfunction

  function automatic int unsigned eff_width();
    if (sh_width == 0) return 1;
    return (sh_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : sh_width;
  endfunction

  function automatic int unsigned eff_height();
    if (sh_height == 0) return 1;
    return (sh_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : sh_height;
  endfunction

  function automatic bit box_mean(input logic op, input logic [15:0] px,
                                  output logic [15:0] res, output logic last);
    int unsigned w, h, r, total, lag, area, q, p, sg, sr, sgr, sb, mean;
    int y, x, j, k, yy, xx, off;
    logic [15:0] v, centre;
    bit hit;
    w = eff_width();
    h = eff_height();
    r = sh_radius;
    total = w * h;
    lag = r * w + r;
    area = (2 * r + 1) * (2 * r + 1);
    q = in_pos;
    p = out_pos;
    sg = 0; sr = 0; sgr = 0; sb = 0;
    res = '0;
    last = 1'b0;
    if (op == OP_DRAIN && q < total) return 0;
    if (op == OP_PIXEL && q < total) pixel_mem[q % STORE_DEPTH] = px;
    if (p >= total) begin
      in_pos = 0;
      out_pos = 0;
      return 0;
    end
    if (q < p + lag) begin
      in_pos = q + 1;
      return 0;
    end
    y = p / w;
    x = p % w;
    for (j = -int'(r); j <= int'(r); j++) begin
      yy = y + j;
      if (yy < 0 || yy >= int'(h)) continue;
      for (k = -int'(r); k <= int'(r); k++) begin
        xx = x + k;
        if (xx < 0 || xx >= int'(w)) continue;
        v = pixel_mem[(yy * w + xx) % STORE_DEPTH];
        sg += v[7:0];
        sr += v[15:11];
        sgr += v[10:5];
        sb += v[4:0];
      end
    end
    centre = pixel_mem[p % STORE_DEPTH];
    off = sh_offset;
    if (!sh_color) begin
      mean = sg / area;
      if (sh_thr_en) begin
        hit = ((int'(mean) - off) < int'(centre[7:0])) != sh_invert;
        res = hit ? 16'd255 : 16'd0;
      end else begin
        res = mean[15:0];
      end
    end else begin
      mean = ((sr / area) << 11) | ((sgr / area) << 5) | (sb / area);
      if (sh_thr_en) begin
        hit = ((luma565(mean[15:0]) - off) < luma565(centre)) != sh_invert;
        res = hit ? 16'hFFFF : 16'd0;
      end else begin
        res = mean[15:0];
      end
    end
    last = (p == total - 1);
    if (last) begin
      in_pos = 0;
      out_pos = 0;
    end else begin
      in_pos = q + 1;
      out_pos = p + 1;
    end
    return 1;
  endfunction

  task automatic send_beat(input logic op, input logic [15:0] px);
    logic [15:0] res;
    logic last;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pixel_in <= px;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    if (box_mean(op, px, res, last)) expected_means.push_back('{res, last});
  endtask

  task automatic drain_out();
    while (expected_means.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIUS: sh_radius = val[2:0];
      REG_WIDTH: sh_width = val[9:0];
      REG_HEIGHT: sh_height = val[8:0];
      REG_COLOR: sh_color = val[0];
      REG_THR_EN: sh_thr_en = val[0];
      REG_THR_OFS: sh_offset = val[8:0];
      REG_INVERT: sh_invert = val[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int r, input int w, input int h, input bit cm,
                           input bit te, input int ofs, input bit inv);
    in_valid <= 1'b0;
    drain_out();
    write_reg(REG_RADIUS, r);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_COLOR, cm);
    write_reg(REG_THR_EN, te);
    write_reg(REG_THR_OFS, ofs & 10'h1FF);
    write_reg(REG_INVERT, inv);
  endtask

  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // one frame: pixels (with stray drains if noise), then drains (and stray pixels if noise) to the end
  task automatic run_frame(input bit noise, input bit hold_mid);
    int unsigned total;
    total = eff_width() * eff_height();
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 15) == 0) send_beat(OP_DRAIN, $urandom);
      if (hold_mid && i == total / 2) begin
        in_valid <= 1'b0;
        while (expected_means.size() != 0) @(posedge clk);
      end
      send_beat(OP_PIXEL, pick_pixel());
    end
    while (in_pos != 0 || out_pos != 0) begin
      if (noise && $urandom_range(0, 5) == 0) send_beat(OP_PIXEL, $urandom);
      else send_beat(OP_DRAIN, $urandom);
    end
  endtask

  task automatic test_directed();
    configure(0, 1, 1, 0, 0, 0, 0);
    run_frame(1'b0, 1'b0);
    configure(7, 3, 3, 0, 0, 0, 0);
    run_frame(1'b1, 1'b0);
    configure(1, 4, 2, 1, 0, 0, 0);
    run_frame(1'b1, 1'b0);
    configure(2, 3, 2, 0, 1, -256, 0);
    run_frame(1'b0, 1'b0);
    configure(1, 2, 3, 1, 1, 255, 1);
    run_frame(1'b0, 1'b0);
  endtask

  task automatic test_size_limits();
    configure(1, 0, 0, 0, 1, 0, 1);
    run_frame(1'b1, 1'b0);
    configure(0, 1023, 1, 1, 0, 0, 0);
    run_frame(1'b0, 1'b0);
    configure(7, 24, 2, 0, 0, 0, 0);
    run_frame(1'b0, 1'b0);
  endtask

  task automatic test_hold_until_empty();
    configure(2, 6, 5, 1, 1, -20, 0);
    run_frame(1'b1, 1'b1);
  endtask

  task automatic test_random_frames();
    while (items_sent < 1450) begin
      if (items_sent > 1300) quiet = 1'b1;
      configure($urandom_range(0, 7), $urandom_range(1, 12), $urandom_range(1, 8),
                $urandom_range(0, 1), $urandom_range(0, 1),
                int'($urandom_range(0, 511)) - 256, $urandom_range(0, 1));
      run_frame(1'b1, 1'b0);
    end
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(negedge clk) begin
    mean_beat_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat pixel_out=%h frame_last=%b", $time, out_pixel_out,
                 out_frame_last);
      end else begin
        exp_b = expected_means.pop_front();
        if (out_pixel_out !== exp_b.pixel) begin
          errors++;
          $display("%0t: pixel_out expected %h actual %h", $time, exp_b.pixel, out_pixel_out);
        end
        if (out_frame_last !== exp_b.last) begin
          errors++;
          $display("%0t: frame_last expected %b actual %b", $time, exp_b.last, out_frame_last);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) pixel_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_size_limits();
    test_hold_until_empty();
    test_random_frames();
    drain_out();
    repeat (300) @(posedge clk);
    if (errors == 0 && expected_means.size() == 0) begin
      $display("box_mean_filter_adaptive_threshold_core_test: clean");
    end else begin
      if (expected_means.size() != 0)
        $display("%0t: %0d expected beats never came", $time, expected_means.size());
      $display("box_mean_filter_adaptive_threshold_core_test: errors");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("box_mean_filter_adaptive_threshold_core_test: errors");
    $finish;
  end
endmodule

FILE: files.f
+incdir+rtl
rtl/bmfat_pkg.sv
rtl/bmfat_ram.sv
rtl/bmfat_queue.sv
rtl/bmfat_front.sv
rtl/bmfat_back.sv
rtl/box_mean_filter_adaptive_threshold_core.sv
test/box_mean_filter_adaptive_threshold_core_test.sv
